// ===== rtl/core/rotary_encoder_button_decoder_macros.svh =====
// assertion macros shared by the rotary encoder decoder rtl
`ifndef ROTARY_ENCODER_BUTTON_DECODER_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define REBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rebd check failed");
// next-cycle implication, disabled during reset
`define REBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rebd check failed");
`else
`define REBD_ASSERT_NOW(label, clk, rst, ante, cons)
`define REBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/rebd_pkg.sv =====
// shared types and constants for the rotary encoder and button decoder
package rebd_pkg;

  localparam int LIMIT_WIDTH = 16;
  localparam int STEPS_WIDTH = 3;

  localparam logic [STEPS_WIDTH-1:0] FAST_LIMIT = 3'd4;
  localparam logic [STEPS_WIDTH-1:0] FAST_SAT   = 3'd5;

  localparam logic LEVEL_PRESSED = 1'b0;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_FAST     = 1'b1;

  localparam logic [LIMIT_WIDTH-1:0] DEBOUNCE_RESET = 16'd5;
  localparam logic [LIMIT_WIDTH-1:0] FAST_RESET     = 16'd30;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_CW       = 3'd1,
    EV_CCW      = 3'd2,
    EV_PRESSED  = 3'd3,
    EV_RELEASED = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef struct packed {
    logic line_a;
    logic line_b;
    logic switch_level;
  } poll_t;

  function automatic event_t dir_to_event(dir_t dir);
    event_t ev;
    case (dir)
      DIR_CW:  ev = EV_CW;
      DIR_CCW: ev = EV_CCW;
      default: ev = EV_NONE;
    endcase
    return ev;
  endfunction

endpackage

// ===== rtl/core/rebd_window.sv =====
// wrapping time window compare: is now still within limit of then
module rebd_window #(
  parameter int TIME_WIDTH = 32
) (
  input  logic [TIME_WIDTH-1:0]            now,
  input  logic [TIME_WIDTH-1:0]            then_time,
  input  logic [rebd_pkg::LIMIT_WIDTH-1:0] limit,
  input  logic                             inclusive,
  output logic                             active
);
  import rebd_pkg::*;

  logic [TIME_WIDTH-1:0] diff;
  logic [TIME_WIDTH-1:0] limit_ext;

  // negative difference counts as fully elapsed
  always_comb begin
    diff      = now - then_time;
    limit_ext = TIME_WIDTH'(limit);
    if (diff[TIME_WIDTH-1]) begin
      active = 1'b0;
    end else if (inclusive) begin
      active = (diff <= limit_ext);
    end else begin
      active = (diff < limit_ext);
    end
  end

endmodule

// ===== rtl/core/rebd_switch.sv =====
// push switch debouncer with press and release reporting
module rebd_switch #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  rebd_pkg::poll_t                  poll,
  input  logic [TIME_WIDTH-1:0]            now,
  input  logic [rebd_pkg::LIMIT_WIDTH-1:0] debounce_ms,
  output rebd_pkg::event_t                 ev
);
  import rebd_pkg::*;

  logic                  last_sample;
  logic                  last_sample_next;
  logic                  accepted;
  logic                  accepted_next;
  logic [TIME_WIDTH-1:0] change_time;
  logic [TIME_WIDTH-1:0] change_time_next;
  logic                  settling;
  logic                  lvl;

  rebd_window #(.TIME_WIDTH(TIME_WIDTH)) u_window (
    .now       (now),
    .then_time (change_time),
    .limit     (debounce_ms),
    .inclusive (1'b0),
    .active    (settling)
  );

  // debounce decision and event
  always_comb begin
    lvl              = poll.switch_level;
    last_sample_next = last_sample;
    accepted_next    = accepted;
    change_time_next = change_time;
    ev               = EV_NONE;
    if (lvl != last_sample) begin
      change_time_next = now;
      last_sample_next = lvl;
    end else if (!settling && (lvl != accepted)) begin
      accepted_next = lvl;
      ev            = (lvl == LEVEL_PRESSED) ? EV_PRESSED : EV_RELEASED;
    end
  end

  // switch state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= 1'b1;
      accepted    <= 1'b1;
      change_time <= '0;
    end else if (en) begin
      last_sample <= last_sample_next;
      accepted    <= accepted_next;
      change_time <= change_time_next;
    end
  end

endmodule

// ===== rtl/core/rebd_wheel.sv =====
// quadrature wheel decoder with debounce and fast rotation filter
module rebd_wheel #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  rebd_pkg::poll_t                  poll,
  input  logic [TIME_WIDTH-1:0]            now,
  input  logic [rebd_pkg::LIMIT_WIDTH-1:0] debounce_ms,
  input  logic [rebd_pkg::LIMIT_WIDTH-1:0] fast_ms,
  output rebd_pkg::event_t                 ev
);
  import rebd_pkg::*;

  logic                   a_accepted;
  logic                   a_accepted_next;
  logic                   a_last_sample;
  logic                   a_last_sample_next;
  logic                   b_last_sample;
  logic                   b_last_sample_next;
  logic [TIME_WIDTH-1:0]  a_change_time;
  logic [TIME_WIDTH-1:0]  a_change_time_next;
  logic [TIME_WIDTH-1:0]  b_change_time;
  logic [TIME_WIDTH-1:0]  b_change_time_next;
  logic [TIME_WIDTH-1:0]  last_step_time;
  logic [TIME_WIDTH-1:0]  last_step_time_next;
  logic [STEPS_WIDTH-1:0] fast_steps;
  logic [STEPS_WIDTH-1:0] fast_steps_next;
  dir_t                   last_direction;
  dir_t                   last_direction_next;

  logic                   a_settling;
  logic                   b_settling;
  logic                   fast;
  logic                   moving;
  logic                   step;
  dir_t                   dir;
  dir_t                   opposite;
  logic [STEPS_WIDTH-1:0] steps_inc;

  rebd_window #(.TIME_WIDTH(TIME_WIDTH)) u_win_a (
    .now       (now),
    .then_time (a_change_time),
    .limit     (debounce_ms),
    .inclusive (1'b0),
    .active    (a_settling)
  );

  rebd_window #(.TIME_WIDTH(TIME_WIDTH)) u_win_b (
    .now       (now),
    .then_time (b_change_time),
    .limit     (debounce_ms),
    .inclusive (1'b0),
    .active    (b_settling)
  );

  rebd_window #(.TIME_WIDTH(TIME_WIDTH)) u_win_fast (
    .now       (now),
    .then_time (last_step_time),
    .limit     (fast_ms),
    .inclusive (1'b1),
    .active    (fast)
  );

  // step detection and direction filter
  always_comb begin
    a_accepted_next     = a_accepted;
    a_last_sample_next  = a_last_sample;
    b_last_sample_next  = b_last_sample;
    a_change_time_next  = a_change_time;
    b_change_time_next  = b_change_time;
    last_step_time_next = last_step_time;
    fast_steps_next     = fast_steps;
    last_direction_next = last_direction;

    dir       = (poll.line_a == poll.line_b) ? DIR_CW : DIR_CCW;
    opposite  = (poll.line_a == poll.line_b) ? DIR_CCW : DIR_CW;
    steps_inc = (fast_steps < FAST_SAT) ? fast_steps + 3'd1 : fast_steps;
    moving    = (poll.line_a != a_last_sample) || (poll.line_b != b_last_sample);

    if (poll.line_a != a_last_sample) begin
      a_last_sample_next = poll.line_a;
      a_change_time_next = now;
    end
    if (poll.line_b != b_last_sample) begin
      b_last_sample_next = poll.line_b;
      b_change_time_next = now;
    end

    step = !moving && !a_settling && !b_settling && (poll.line_a != a_accepted);

    if (step) begin
      a_accepted_next     = poll.line_a;
      last_step_time_next = now;
      if (!fast) begin
        last_direction_next = dir;
        fast_steps_next     = '0;
      end else if (last_direction != opposite) begin
        fast_steps_next = steps_inc;
        if (steps_inc > FAST_LIMIT) begin
          last_direction_next = dir;
        end
      end
    end

    ev = step ? dir_to_event(last_direction_next) : EV_NONE;
  end

  // wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_accepted     <= 1'b1;
      a_last_sample  <= 1'b1;
      b_last_sample  <= 1'b1;
      a_change_time  <= '0;
      b_change_time  <= '0;
      last_step_time <= '0;
      fast_steps     <= '0;
      last_direction <= DIR_NONE;
    end else if (en) begin
      a_accepted     <= a_accepted_next;
      a_last_sample  <= a_last_sample_next;
      b_last_sample  <= b_last_sample_next;
      a_change_time  <= a_change_time_next;
      b_change_time  <= b_change_time_next;
      last_step_time <= last_step_time_next;
      fast_steps     <= fast_steps_next;
      last_direction <= last_direction_next;
    end
  end

endmodule

// ===== rtl/core/rotary_encoder_button_decoder.sv =====
// rotary encoder and push switch decoder, top level
// poll items pass through the input holding register, then the result register
// throughput: one poll item per cycle while not stalled; state updates in the
//   same cycle as the compare logic between the input holding and result registers
// reset: synchronous rst clears all pipeline valids and state, and loads
//   debounce_ms = 5 and fast_ms = 30; configuration is always ready
`include "rotary_encoder_button_decoder_macros.svh"

module rotary_encoder_button_decoder #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             line_a,
  input  logic                             line_b,
  input  logic                             switch_level,
  input  logic [31:0]                      now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rebd_pkg::event_t                 event_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [rebd_pkg::LIMIT_WIDTH-1:0] cfg_data
);
  import rebd_pkg::*;

  logic [LIMIT_WIDTH-1:0] debounce_ms;
  logic [LIMIT_WIDTH-1:0] fast_ms;

  logic                   hold_valid;
  poll_t                  hold_poll;
  logic [TIME_WIDTH-1:0]  hold_now;

  logic                   in_accept;
  logic                   step_en;
  event_t                 sw_event;
  event_t                 wheel_event;
  event_t                 result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      fast_ms     <= FAST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ms <= cfg_data;
        REG_FAST:     fast_ms     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // handshake: the holding register drains whenever the result register can take
  assign step_en   = hold_valid && !(out_valid && out_stall);
  assign in_stall  = hold_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
    end else if (step_en) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_poll.line_a       <= line_a;
      hold_poll.line_b       <= line_b;
      hold_poll.switch_level <= switch_level;
      hold_now               <= TIME_WIDTH'(now_ms);
    end
  end

  rebd_switch #(.TIME_WIDTH(TIME_WIDTH)) u_switch (
    .clk         (clk),
    .rst         (rst),
    .en          (step_en),
    .poll        (hold_poll),
    .now         (hold_now),
    .debounce_ms (debounce_ms),
    .ev          (sw_event)
  );

  rebd_wheel #(.TIME_WIDTH(TIME_WIDTH)) u_wheel (
    .clk         (clk),
    .rst         (rst),
    .en          (step_en),
    .poll        (hold_poll),
    .now         (hold_now),
    .debounce_ms (debounce_ms),
    .fast_ms     (fast_ms),
    .ev          (wheel_event)
  );

  // switch events take priority over the wheel
  assign result = (sw_event != EV_NONE) ? sw_event : wheel_event;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      event_res <= result;
    end
  end

  `REBD_ASSERT_NEXT(a_step_makes_result, clk, rst, step_en, out_valid)
  `REBD_ASSERT_NEXT(a_switch_overrides, clk, rst, step_en && (sw_event != EV_NONE), event_res == $past(sw_event))
  `REBD_ASSERT_NEXT(a_wheel_passes, clk, rst, step_en && (sw_event == EV_NONE), event_res == $past(wheel_event))
  `REBD_ASSERT_NEXT(a_output_drains, clk, rst, out_valid && !out_stall && !step_en, !out_valid)

endmodule
